// ===== sv/srtt_pkg.sv =====
package srtt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int ADDR_W = 64;
	localparam int LEN_W  = 31;
	localparam int FBASE_W = 48;
	localparam int OFFS_W = 49;

	// command codes carried in the input tuser
	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// one stored region, end kept at 65 bits so lookups need no adder to form it
	typedef struct packed {
		logic [ADDR_W-1:0]  start;
		logic [ADDR_W:0]    stop;
		logic [FBASE_W-1:0] fbase;
	} entry_t;

	// lookup token that walks the cell chain
	typedef struct packed {
		logic               act;
		logic [ADDR_W-1:0]  sum;
		logic               done;
		logic               hit;
		logic [OFFS_W-1:0]  diff;
		logic [FBASE_W-1:0] fbase;
	} query_t;

endpackage

// ===== sv/srtt_cell.sv =====
module srtt_cell
	import srtt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   ins_en,
	input  entry_t ins_entry,
	input  entry_t prev_entry,
	input  logic   prev_gt,
	input  logic   in_use,
	input  logic   at_tail,
	output logic   gt,
	output entry_t entry,
	input  query_t q_in,
	output query_t q_out
);

	entry_t entry_q;
	query_t q_s1;
	query_t q_nxt;
	logic   match;

	assign entry = entry_q;
	assign q_out = q_s1;

	// this entry sorts strictly after the new one
	assign gt = in_use && (entry_q.start > ins_entry.start);

	always_ff @(posedge clk) begin
		if (ins_en) begin
			if (prev_gt) begin
				entry_q <= prev_entry;
			end else if (gt || at_tail) begin
				entry_q <= ins_entry;
			end
		end
	end

	// first entry whose end lies above the address stops the scan
	assign match = q_in.act && !q_in.done && in_use && (entry_q.stop > {1'b0, q_in.sum});

	always_comb begin
		q_nxt = q_in;
		if (match) begin
			q_nxt.done  = 1'b1;
			q_nxt.hit   = (entry_q.start <= q_in.sum);
			q_nxt.diff  = q_in.sum[OFFS_W-1:0] - entry_q.start[OFFS_W-1:0];
			q_nxt.fbase = entry_q.fbase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_s1 <= '0;
		end else begin
			q_s1 <= q_nxt;
		end
	end

endmodule

// ===== sv/sorted_range_translation_table.sv =====
// timing: an add shows its result in the cycle after its beat, a lookup passes the
// injection stage, one cell stage per entry and the result register
// flow: one item at a time; a new beat is taken only once the result of the
// item before it has been taken
// reset: arst_n clears the entry count, lookup_base and all handshake state
// at once; entry contents are left as they are
module sorted_range_translation_table
	import srtt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	// input beats
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [143:0]  s_axis_tdata,  // mem_address[63:0], region_length[94:64],
	                                     // file_base[142:95], zero[143]
	input  logic [0:0]    s_axis_tuser,  // cmd[0]
	// result beats
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [55:0]   m_axis_tdata,  // file_offset[48:0], zero[55:49]
	output logic [1:0]    m_axis_tuser,  // hit[0], table_full[1]
	// lookup_base register
	input  logic          cfg_we,
	input  logic [63:0]   cfg_wdata
);

	logic [ADDR_W-1:0]  lookup_base_q;
	logic [CNT_W-1:0]   count_q;
	logic               busy_q;
	logic               out_valid_q;
	logic               out_hit_q;
	logic               out_full_q;
	logic [OFFS_W-1:0]  out_offset_q;

	logic               in_beat;
	logic               out_beat;
	logic               is_add;
	logic               is_full;
	logic               ins_en;
	logic [ADDR_W-1:0]  in_addr;
	logic [LEN_W-1:0]   in_len;
	logic [FBASE_W-1:0] in_fbase;
	entry_t             ins_entry;

	entry_t             cell_entry [TABLE_DEPTH];
	logic               cell_gt    [TABLE_DEPTH];
	query_t             chain      [TABLE_DEPTH+1];
	query_t             query_q;
	query_t             tail_q;

	// unpack the input beat
	assign in_addr  = s_axis_tdata[63:0];
	assign in_len   = s_axis_tdata[94:64];
	assign in_fbase = s_axis_tdata[142:95];

	// handshakes; one item is in flight from its beat until its result is taken
	assign s_axis_tready = !busy_q;
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_beat      = m_axis_tvalid && m_axis_tready;

	assign is_add  = (s_axis_tuser[0] == CMD_ADD);
	assign is_full = (count_q == CNT_W'(TABLE_DEPTH));
	assign ins_en  = in_beat && is_add && !is_full;

	// new entry with its end precomputed at 65 bits
	always_comb begin
		ins_entry.start = in_addr;
		ins_entry.stop  = {1'b0, in_addr} + {{(ADDR_W + 1 - LEN_W){1'b0}}, in_len};
		ins_entry.fbase = in_fbase;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookup_base_q <= '0;
		end else if (cfg_we) begin
			lookup_base_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ins_en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// injection stage: lookup address plus base, wrapping at 64 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q <= '0;
		end else begin
			query_q.act   <= in_beat && !is_add;
			query_q.sum   <= in_addr + lookup_base_q;
			query_q.done  <= 1'b0;
			query_q.hit   <= 1'b0;
			query_q.diff  <= '0;
			query_q.fbase <= '0;
		end
	end

	assign chain[0] = query_q;

	// row of cells: sorted shift insert and the walking lookup token
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		entry_t prev_entry;
		logic   prev_gt;

		if (i == 0) begin : g_head
			assign prev_entry = cell_entry[0];
			assign prev_gt    = 1'b0;
		end else begin : g_body
			assign prev_entry = cell_entry[i-1];
			assign prev_gt    = cell_gt[i-1];
		end

		srtt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ins_en     (ins_en),
			.ins_entry  (ins_entry),
			.prev_entry (prev_entry),
			.prev_gt    (prev_gt),
			.in_use     (CNT_W'(i) < count_q),
			.at_tail    (CNT_W'(i) == count_q),
			.gt         (cell_gt[i]),
			.entry      (cell_entry[i]),
			.q_in       (chain[i]),
			.q_out      (chain[i+1])
		);
	end

	assign tail_q = chain[TABLE_DEPTH];

	// result register; add results load at the beat, lookups at the chain end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_beat) begin
				busy_q <= 1'b1;
			end else if (out_beat) begin
				busy_q <= 1'b0;
			end
			if ((in_beat && is_add) || tail_q.act) begin
				out_valid_q <= 1'b1;
			end else if (out_beat) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat && is_add) begin
			out_hit_q    <= 1'b0;
			out_full_q   <= is_full;
			out_offset_q <= '0;
		end else if (tail_q.act) begin
			out_hit_q    <= tail_q.hit;
			out_full_q   <= 1'b0;
			out_offset_q <= tail_q.hit ? ({1'b0, tail_q.fbase} + tail_q.diff) : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(56 - OFFS_W){1'b0}}, out_offset_q};
	assign m_axis_tuser  = {out_full_q, out_hit_q};

	// a waiting result blocks new input
	a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input accepted while a result is pending");

	// an add beat yields its result on the next cycle
	a_add_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && is_add) |=> m_axis_tvalid)
		else $error("add result missing");

	// a lookup token never reaches the end of the chain over a pending result
	a_tail_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q.act |-> (!out_valid_q && busy_q))
		else $error("lookup completed over a pending result");

	// the entry count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

endmodule
